### rtl/sur_pkg.sv
// Shared constants, register indexes and types of the staggered ultrasonic ranger.
package sur_pkg;

    localparam int CHANNELS_DEF = 4;

    localparam int PERIOD_W  = 16;
    localparam int TRIG_W    = 8;
    localparam int TIMEOUT_W = 24;
    localparam int TIME_W    = 32;
    localparam int RISE_W    = PERIOD_W + 1;
    localparam int FALL_W    = RISE_W + 1;
    localparam int ECHO_W    = 4;
    localparam int OUT_CH_W  = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    localparam logic [PERIOD_W-1:0]  RESET_PERIOD  = 16'd60;
    localparam logic [TRIG_W-1:0]    RESET_TRIG    = 8'd1;
    localparam logic [TIMEOUT_W-1:0] RESET_TIMEOUT = 24'd1000000;

    typedef struct packed {
        logic advance;
        logic start;
    } t_meas_ctl;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [TIMEOUT_W-1:0] duration_us;
    } t_meas_res;

    typedef struct packed {
        logic [ECHO_W-1:0]    trigger_levels;
        logic                 done_res;
        logic [OUT_CH_W-1:0]  channel;
        logic [TIMEOUT_W-1:0] duration_us;
    } t_result;

endpackage

### rtl/sur_echo_meter.sv
// Echo pulse width measurement of one selected channel at a time.
module sur_echo_meter #(
    parameter int CHANNELS = sur_pkg::CHANNELS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  sur_pkg::t_meas_ctl                         i_ctl,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_start_ch,
    input  logic [sur_pkg::ECHO_W-1:0]                 i_echo_levels,
    input  logic [sur_pkg::TIMEOUT_W-1:0]              i_timeout_us,
    output sur_pkg::t_meas_res                         o_res,
    output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] o_channel
);
    import sur_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_LOW,
        PH_WAIT_HIGH,
        PH_COUNT
    } t_phase;

    t_phase               r_phase;
    logic [CW-1:0]        r_ch;
    logic [TIMEOUT_W-1:0] r_wait;
    logic [TIMEOUT_W-1:0] r_width;

    logic [CW+1:0]        ch_pad;
    logic                 level;
    logic [TIMEOUT_W-1:0] n_wait;
    logic                 busy;
    logic                 pulse_end;
    logic                 timed_out;
    logic                 done;

    // Channels above the echo bus width read a low echo.
    assign ch_pad    = {2'b00, r_ch};
    assign level     = (ch_pad[CW+1:2] == '0) && i_echo_levels[ch_pad[1:0]];
    assign n_wait    = r_wait + TIMEOUT_W'(1);
    assign busy      = (r_phase != PH_IDLE);
    assign pulse_end = (r_phase == PH_COUNT) && !level;
    assign timed_out = !pulse_end && (n_wait >= i_timeout_us);
    assign done      = i_ctl.advance && busy && (pulse_end || timed_out);

    assign o_res.busy        = busy;
    assign o_res.done        = done;
    assign o_res.duration_us = (done && pulse_end) ? r_width : '0;
    assign o_channel         = r_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ch    <= '0;
            r_wait  <= '0;
            r_width <= '0;
        end else if (i_ctl.start) begin
            r_phase <= PH_WAIT_LOW;
            r_ch    <= i_start_ch;
            r_wait  <= '0;
            r_width <= '0;
        end else if (i_ctl.advance && busy) begin
            r_wait <= n_wait;
            case (r_phase)
                PH_WAIT_LOW: begin
                    if (!level) begin
                        r_phase <= PH_WAIT_HIGH;
                    end
                end
                PH_WAIT_HIGH: begin
                    if (level) begin
                        r_phase <= PH_COUNT;
                        r_width <= TIMEOUT_W'(1);
                    end
                end
                PH_COUNT: begin
                    if (level) begin
                        r_width <= r_width + TIMEOUT_W'(1);
                    end
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
            // Finish: drop back to idle and clear the counters.
            if (done) begin
                r_phase <= PH_IDLE;
                r_wait  <= '0;
                r_width <= '0;
            end
        end
    end

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (r_phase == PH_IDLE))
        else $error("measurement started while another one runs");

    a_idle_counts_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_wait == '0 && r_width == '0))
        else $error("counters not cleared while idle");

    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.done |=> (r_phase == PH_IDLE))
        else $error("meter did not return to idle after finishing");

endmodule

### rtl/staggered_ultrasonic_ranger.sv
// Top level of the staggered ultrasonic ranger: schedule, config registers, output skid.
//
// One input item is one microsecond tick: a millisecond strobe and the echo level of every
// channel. Each accepted item yields exactly one result item holding the trigger drive after
// that tick and, on the tick where an echo measurement ends, done_res with the channel and the
// echo high time in microseconds (0 on timeout). Channel i triggers once the milliseconds since
// its last start reach period_ms + i*(period_ms/CHANNELS) and holds the trigger trigger_ms
// longer; note the offset adds to every period, not only the first. At the trigger fall the
// channel's start time is set to now and a pulseIn-style echo measurement begins on the next
// tick; the schedule stays frozen until it ends. Lower channel indexes win when several fall
// together. The block takes one item per clock cycle while o_stall is low: each tick is done
// by one pass of logic from the state registers into a result register, and a two-entry output
// (result register plus skid register) lets a new item enter while a result still waits.
// o_stall rises only when both entries are full. The per-channel rise times are derived from
// period_ms at the configuration write (a reciprocal multiply), so write period_ms only while
// idle. Configuration writes to index 3 are ignored.
module staggered_ultrasonic_ranger #(
    parameter int CHANNELS = sur_pkg::CHANNELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tick input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_ms_strobe,
    input  logic [sur_pkg::ECHO_W-1:0]        i_echo_levels,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [sur_pkg::ECHO_W-1:0]        o_trigger_levels,
    output logic                              o_done_res,
    output logic [sur_pkg::OUT_CH_W-1:0]      o_channel,
    output logic [sur_pkg::TIMEOUT_W-1:0]     o_duration_us,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [sur_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sur_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import sur_pkg::*;

    localparam int CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RL      = $clog2(CHANNELS);
    localparam int RSH     = PERIOD_W + RL;
    localparam int PROD_W  = RSH + PERIOD_W;
    // Reciprocal of CHANNELS, exact for every 16-bit period.
    localparam int RECIP   = ((1 << RSH) + CHANNELS - 1) / CHANNELS;
    localparam int RESET_Q = int'(RESET_PERIOD) / CHANNELS;

    // Configuration registers.
    logic [TRIG_W-1:0]    r_trig_ms;
    logic [TIMEOUT_W-1:0] r_timeout_us;
    logic [RISE_W-1:0]    r_rise_at [CHANNELS];

    // Schedule state.
    logic [TIME_W-1:0]    r_now;
    logic [TIME_W-1:0]    r_last [CHANNELS];
    logic [CHANNELS-1:0]  r_trig;

    // Output register and skid stage.
    logic                 r_out_valid;
    t_result              r_out;
    logic                 r_skid_valid;
    t_result              r_skid;

    logic [PROD_W-1:0]    cfg_prod;
    logic [PERIOD_W-1:0]  cfg_q;
    logic [TIME_W-1:0]    n_now;
    logic [TIME_W-1:0]    elapsed [CHANNELS];
    logic [FALL_W-1:0]    fall_at [CHANNELS];
    logic [CHANNELS-1:0]  arm;
    logic [CHANNELS-1:0]  fall;
    logic [CHANNELS-1:0]  n_trig;
    logic [TIME_W-1:0]    n_last [CHANNELS];
    logic                 fall_any;
    logic [CW-1:0]        fall_ch;

    logic                 in_accept;
    logic                 out_take;
    logic                 sched;
    t_meas_ctl            meas_ctl;
    t_meas_res            meas_res;
    logic [CW-1:0]        meas_ch;
    logic [CW+1:0]        meas_ch_pad;
    logic [CHANNELS-1:0]  trig_after;
    logic [CHANNELS+3:0]  trig_pad;
    t_result              res;

    assign in_accept = i_valid && !r_skid_valid;
    assign o_stall   = r_skid_valid;
    assign out_take  = r_out_valid && !i_stall;

    // Offset per channel is period/CHANNELS; reduce it once at the write.
    assign cfg_prod = PROD_W'(i_cfg_data[PERIOD_W-1:0]) * PROD_W'(RECIP);
    assign cfg_q    = cfg_prod[RSH +: PERIOD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_ms    <= RESET_TRIG;
            r_timeout_us <= RESET_TIMEOUT;
            for (int i = 0; i < CHANNELS; i++) begin
                r_rise_at[i] <= RISE_W'(int'(RESET_PERIOD) + i * RESET_Q);
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PERIOD: begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        r_rise_at[i] <= RISE_W'(i_cfg_data[PERIOD_W-1:0])
                                      + RISE_W'(TIME_W'(i) * TIME_W'(cfg_q));
                    end
                end
                CFG_TRIGGER: r_trig_ms    <= i_cfg_data[TRIG_W-1:0];
                CFG_TIMEOUT: r_timeout_us <= i_cfg_data[TIMEOUT_W-1:0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // Advance the millisecond count first; every check sees the new time.
    assign n_now = r_now + TIME_W'(i_ms_strobe);

    // Scan in index order; the first falling channel blocks the rest.
    always_comb begin
        fall_any = 1'b0;
        fall_ch  = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            elapsed[i] = n_now - r_last[i];
            fall_at[i] = FALL_W'(r_rise_at[i]) + FALL_W'(r_trig_ms);
            arm[i]     = r_trig[i] || (elapsed[i] >= TIME_W'(r_rise_at[i]));
            fall[i]    = arm[i] && (elapsed[i] >= TIME_W'(fall_at[i]));
            n_trig[i]  = r_trig[i];
            n_last[i]  = r_last[i];
            if (!fall_any) begin
                n_trig[i] = arm[i] && !fall[i];
                if (fall[i]) begin
                    n_last[i] = n_now;
                    fall_any  = 1'b1;
                    fall_ch   = CW'(i);
                end
            end
        end
    end

    // Hold the schedule frozen while a measurement runs.
    assign sched            = in_accept && !meas_res.busy;
    assign meas_ctl.advance = in_accept;
    assign meas_ctl.start   = sched && fall_any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now  <= '0;
            r_trig <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_last[i] <= TIME_W'(i * RESET_Q);
            end
        end else begin
            if (in_accept) begin
                r_now <= n_now;
            end
            if (sched) begin
                r_trig <= n_trig;
                r_last <= n_last;
            end
        end
    end

    sur_echo_meter #(
        .CHANNELS (CHANNELS)
    ) u_meter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (meas_ctl),
        .i_start_ch    (fall_ch),
        .i_echo_levels (i_echo_levels),
        .i_timeout_us  (r_timeout_us),
        .o_res         (meas_res),
        .o_channel     (meas_ch)
    );

    // Build the result; channels past the output width are dropped.
    assign trig_after  = sched ? n_trig : r_trig;
    assign trig_pad    = {4'b0000, trig_after};
    assign meas_ch_pad = {2'b00, meas_ch};

    assign res.trigger_levels = trig_pad[ECHO_W-1:0];
    assign res.done_res       = meas_res.done;
    assign res.channel        = meas_res.done ? meas_ch_pad[OUT_CH_W-1:0] : '0;
    assign res.duration_us    = meas_res.duration_us;

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_trigger_levels = r_out.trigger_levels;
    assign o_done_res       = r_out.done_res;
    assign o_channel        = r_out.channel;
    assign o_duration_us    = r_out.duration_us;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds an item while the output register is empty");

    a_frozen_schedule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && meas_res.busy) |=> $stable(r_trig))
        else $error("trigger changed while a measurement runs");

    a_one_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        meas_ctl.start |=> ($countones(r_trig ^ $past(r_trig)) <= CHANNELS)
                            && meas_res.busy)
        else $error("measurement start did not make the meter busy");

endmodule

### tb/tb_staggered_ultrasonic_ranger.sv
// Self-checking testbench of the staggered ultrasonic ranger: tick driver, result monitor.
`timescale 1ns / 100ps

module tb_staggered_ultrasonic_ranger;

    import sur_pkg::*;

    localparam int CHANNELS      = CHANNELS_DEF;
    localparam int RANDOM_TICKS  = 1600;
    // Longest legal silence: a long sender gap plus a long receiver stall, with margin.
    localparam int QUIET_LIMIT   = 1000;
    // Cycles to let pass once everything is drained; covers result register plus skid.
    localparam int SETTLE_CYCLES = 8;

    // Index 3 decodes to no register; writes there must leave the block alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        ECHO_IDLE,
        ECHO_WAIT_LOW,
        ECHO_WAIT_HIGH,
        ECHO_COUNT
    } t_echo_phase;

    typedef struct packed {
        logic              ms_strobe;
        logic [ECHO_W-1:0] echo_levels;
    } t_tick;

    // ---------------------------------------------------------------- DUT ports
    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_valid          = 1'b0;
    logic                  o_stall;
    logic                  i_ms_strobe      = 1'b0;
    logic [ECHO_W-1:0]     i_echo_levels    = '0;
    logic                  o_valid;
    logic                  i_stall          = 1'b0;
    logic [ECHO_W-1:0]     o_trigger_levels;
    logic                  o_done_res;
    logic [OUT_CH_W-1:0]   o_channel;
    logic [TIMEOUT_W-1:0]  o_duration_us;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx        = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;

    staggered_ultrasonic_ranger #(
        .CHANNELS(CHANNELS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_ms_strobe     (i_ms_strobe),
        .i_echo_levels   (i_echo_levels),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_trigger_levels(o_trigger_levels),
        .o_done_res      (o_done_res),
        .o_channel       (o_channel),
        .o_duration_us   (o_duration_us),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- ranger shadow
    // Register copies, loaded from the write port exactly when the block loads them.
    logic [PERIOD_W-1:0]  cfg_period  = RESET_PERIOD;
    logic [TRIG_W-1:0]    cfg_trigger = RESET_TRIG;
    logic [TIMEOUT_W-1:0] cfg_timeout = RESET_TIMEOUT;

    // Schedule and echo measurement state.
    logic [TIME_W-1:0]    now_ms;
    logic [TIME_W-1:0]    start_ms [CHANNELS];
    logic [CHANNELS-1:0]  armed;
    t_echo_phase          echo_phase;
    logic [OUT_CH_W-1:0]  meas_ch;
    logic [TIMEOUT_W-1:0] wait_us;
    logic [TIMEOUT_W-1:0] width_us;

    initial begin
        now_ms     = '0;
        armed      = '0;
        echo_phase = ECHO_IDLE;
        meas_ch    = '0;
        wait_us    = '0;
        width_us   = '0;
        // Stagger the start times by the offsets of the reset period.
        for (int ch = 0; ch < CHANNELS; ch++) begin
            start_ms[ch] = TIME_W'(ch) * TIME_W'(RESET_PERIOD / CHANNELS);
        end
    end

    // Advance the shadow by one microsecond tick and return the result it produces.
    task automatic advance_ranger(input logic strobe, input logic [ECHO_W-1:0] echo,
                                  output t_result res);
        logic                 level;
        logic                 finished;
        logic [TIMEOUT_W-1:0] dur;
        logic [OUT_CH_W-1:0]  fin_ch;
        logic [TIME_W-1:0]    elapsed;
        logic [TIME_W-1:0]    rise_at;
        logic                 fired;
        int                   ch;
        finished = 1'b0;
        dur      = '0;
        fin_ch   = '0;
        fired    = 1'b0;

        if (strobe) begin
            now_ms = now_ms + 1'b1;
        end

        if (echo_phase != ECHO_IDLE) begin
            // A measurement runs: the schedule holds still.
            level   = echo[meas_ch];
            wait_us = wait_us + 1'b1;
            case (echo_phase)
                ECHO_WAIT_LOW: begin
                    if (!level) echo_phase = ECHO_WAIT_HIGH;
                end
                ECHO_WAIT_HIGH: begin
                    if (level) begin
                        echo_phase = ECHO_COUNT;
                        width_us   = TIMEOUT_W'(1);
                    end
                end
                default: begin
                    if (level) begin
                        width_us = width_us + 1'b1;
                    end else begin
                        finished = 1'b1;
                        dur      = width_us;
                    end
                end
            endcase
            // The pulse end takes precedence over a timeout on the same tick.
            if (!finished && wait_us >= cfg_timeout) begin
                finished = 1'b1;
                dur      = '0;
            end
            if (finished) begin
                fin_ch     = meas_ch;
                echo_phase = ECHO_IDLE;
                wait_us    = '0;
                width_us   = '0;
            end
        end else begin
            // Scan in index order; the first trigger fall starts a measurement and ends the scan.
            // Elapsed time wraps, so a start time ahead of now reads as long overdue.
            for (ch = 0; ch < CHANNELS && !fired; ch++) begin
                elapsed = now_ms - start_ms[ch];
                rise_at = TIME_W'(cfg_period) + TIME_W'(ch) * TIME_W'(cfg_period / CHANNELS);
                if (!armed[ch] && elapsed >= rise_at) begin
                    armed[ch] = 1'b1;
                end
                if (armed[ch] && elapsed >= rise_at + TIME_W'(cfg_trigger)) begin
                    armed[ch]    = 1'b0;
                    start_ms[ch] = now_ms;
                    echo_phase   = ECHO_WAIT_LOW;
                    meas_ch      = OUT_CH_W'(ch);
                    wait_us      = '0;
                    width_us     = '0;
                    fired        = 1'b1;
                end
            end
        end

        res.trigger_levels = armed;
        res.done_res       = finished;
        res.channel        = fin_ch;
        res.duration_us    = dur;
    endtask

    // ---------------------------------------------------------------- bookkeeping
    t_tick   tick_q [$];          // ticks waiting to be driven
    t_result readings_due [$];    // expected results, oldest first
    t_tick   next_tick;
    t_result due;
    t_result got;

    int  ticks_queued     = 0;
    int  ticks_accepted   = 0;
    int  ticks_random     = 0;
    int  results_seen     = 0;
    int  readings_done    = 0;
    int  readings_timeout = 0;
    int  settings_used    = 0;
    int  error_count      = 0;
    int  quiet_cycles     = 0;
    int  send_gap         = 0;
    int  stall_left       = 0;
    bit  send_quiet       = 1'b0;
    bit  stall_quiet      = 1'b0;
    logic tick_taken      = 1'b0;

    // Echo waveform state: alternate low gaps and high pulses on a channel mask.
    bit                pulse_on   = 1'b0;
    int                run_left   = 0;
    logic [ECHO_W-1:0] pulse_mask = '1;

    task automatic flag_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] want);
        $display("mismatch at result %0d: %s got 0x%0h, want 0x%0h",
                 results_seen, what, seen, want);
        error_count++;
    endtask

    // Mostly no pause, sometimes a short one, rarely a long one.
    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // Next echo sample: pulses long enough to hit timeouts now and then, plus some noise.
    function automatic logic [ECHO_W-1:0] next_echo();
        logic [ECHO_W-1:0] lv;
        if (run_left == 0) begin
            pulse_on = !pulse_on;
            if (pulse_on) begin
                pulse_mask = $urandom_range(0, 1) ? '1 : ECHO_W'($urandom);
                run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 300)
                                                         : $urandom_range(1, 25);
            end else begin
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 6);
            end
        end
        run_left--;
        lv = pulse_on ? pulse_mask : '0;
        if ($urandom_range(0, 9) == 0) lv = ECHO_W'($urandom);
        return lv;
    endfunction

    task automatic queue_tick(input logic strobe, input logic [ECHO_W-1:0] echo);
        tick_q.push_back('{ms_strobe: strobe, echo_levels: echo});
        ticks_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Load all registers; put junk above the narrow fields and poke the spare index.
    task automatic set_registers(input logic [PERIOD_W-1:0] period,
                                 input logic [TRIG_W-1:0] trig,
                                 input logic [TIMEOUT_W-1:0] timeout);
        write_reg(CFG_PERIOD,  {8'($urandom), period});
        write_reg(CFG_TRIGGER, {16'($urandom), trig});
        write_reg(CFG_TIMEOUT, timeout);
        write_reg(CFG_SPARE,   CFG_DATA_W'($urandom));
        settings_used++;
        @(posedge i_clk);
    endtask

    // Hold until every tick is taken and every result has come back, then settle.
    task automatic wait_drained();
        while (ticks_accepted != ticks_queued || readings_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------- tick driver
    // Present a new tick only once the previous one is gone; a stalled tick holds still.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || tick_taken)) begin
            if (send_gap == 0 && tick_q.size() != 0) begin
                next_tick = tick_q.pop_front();
                i_valid       <= 1'b1;
                i_ms_strobe   <= next_tick.ms_strobe;
                i_echo_levels <= next_tick.echo_levels;
                send_gap = send_quiet ? 0 : pick_pause();
            end else begin
                i_valid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end
        end
    end

    // Receiver back-pressure, independent of o_valid.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            if (!stall_quiet) stall_left = pick_pause();
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        tick_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PERIOD:  cfg_period  = i_cfg_data[PERIOD_W-1:0];
                    CFG_TRIGGER: cfg_trigger = i_cfg_data[TRIG_W-1:0];
                    CFG_TIMEOUT: cfg_timeout = i_cfg_data[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end

            // Predict on acceptance so the expectation sits in the store before its result.
            if (i_valid && !o_stall) begin
                advance_ranger(i_ms_strobe, i_echo_levels, due);
                readings_due.push_back(due);
                ticks_accepted++;
                if (due.done_res) begin
                    readings_done++;
                    if (due.duration_us == '0) readings_timeout++;
                end
            end

            if (o_valid && !i_stall) begin
                got = '{trigger_levels: o_trigger_levels, done_res: o_done_res,
                        channel: o_channel, duration_us: o_duration_us};
                if (readings_due.size() == 0) begin
                    flag_mismatch("result with nothing expected", 32'(got), '0);
                end else begin
                    due = readings_due.pop_front();
                    if (got.trigger_levels !== due.trigger_levels)
                        flag_mismatch("trigger_levels", 32'(got.trigger_levels),
                                      32'(due.trigger_levels));
                    if (got.done_res !== due.done_res)
                        flag_mismatch("done_res", 32'(got.done_res), 32'(due.done_res));
                    if (got.channel !== due.channel)
                        flag_mismatch("channel", 32'(got.channel), 32'(due.channel));
                    if (got.duration_us !== due.duration_us)
                        flag_mismatch("duration_us", 32'(got.duration_us),
                                      32'(due.duration_us));
                end
                results_seen++;
            end
        end

        // Watchdog: any handshake or register write counts as progress.
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no handshake for %0d cycles", QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    initial begin
        logic [PERIOD_W-1:0]  period;
        logic [TRIG_W-1:0]    trig;
        logic [TIMEOUT_W-1:0] timeout;
        int                   strobe_every;
        int                   phase_len;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: channels 1..3 start ahead of now, so each rises and falls at once.
        // Channel 1: echo already high, drop, then a two-tick pulse.
        queue_tick(1'b1, 4'b0000); queue_tick(1'b0, 4'b1111); queue_tick(1'b0, 4'b0000);
        queue_tick(1'b0, 4'b1111); queue_tick(1'b0, 4'b0010); queue_tick(1'b0, 4'b1101);
        // Channel 2: low at once, one-tick pulse.
        queue_tick(1'b1, 4'b0000); queue_tick(1'b0, 4'b0000); queue_tick(1'b0, 4'b0100);
        queue_tick(1'b0, 4'b1011);
        // Channel 3: triggered with every echo high, other channels must not matter.
        queue_tick(1'b1, 4'b1111); queue_tick(1'b0, 4'b0111); queue_tick(1'b0, 4'b1000);
        queue_tick(1'b0, 4'b1000); queue_tick(1'b0, 4'b0000);
        wait_drained();

        // Shortest period: channel 0 rises, falls, and its pulse ends on the timeout tick.
        set_registers(16'd4, 8'd1, 24'd6);
        queue_tick(1'b1, 4'b0000); queue_tick(1'b1, 4'b0000); queue_tick(1'b0, 4'b0000);
        queue_tick(1'b0, 4'b1111); queue_tick(1'b0, 4'b1111); queue_tick(1'b0, 4'b1111);
        queue_tick(1'b0, 4'b1111); queue_tick(1'b0, 4'b1110);
        wait_drained();

        // Zero timeout: channel 1 measures and gives up on its first tick.
        set_registers(16'd4, 8'd1, 24'd0);
        queue_tick(1'b1, 4'b0000); queue_tick(1'b1, 4'b0000); queue_tick(1'b0, 4'b1111);
        wait_drained();

        // Random phases; each one drains fully before the registers move, which also
        // holds the sender until every expected result is back.
        while (ticks_random < RANDOM_TICKS) begin
            strobe_every = 1;
            case (settings_used)
                3: begin period = 16'd4;     trig = 8'd1;   timeout = 24'd1;       phase_len = 120; end
                4: begin period = 16'hFFFF;  trig = 8'hFF;  timeout = 24'hFFFFFF;  phase_len = 60;  end
                5: begin period = RESET_PERIOD; trig = RESET_TRIG; timeout = RESET_TIMEOUT;
                         phase_len = 200; end
                6: begin period = 16'd6;     trig = 8'hFF;  timeout = 24'd40;      phase_len = 150; end
                7: begin period = 16'd8;     trig = 8'd2;   timeout = 24'd0;
                         strobe_every = 2;   phase_len = 100; end
                default: begin
                    period       = PERIOD_W'($urandom_range(4, 16));
                    trig         = TRIG_W'($urandom_range(1, 4));
                    timeout      = $urandom_range(0, 1) ? TIMEOUT_W'($urandom_range(1, 30))
                                                        : TIMEOUT_W'($urandom_range(31, 400));
                    strobe_every = $urandom_range(1, 4);
                    phase_len    = $urandom_range(100, 200);
                end
            endcase
            send_quiet  = ($urandom_range(0, 3) == 0);
            stall_quiet = ($urandom_range(0, 3) == 0);
            set_registers(period, trig, timeout);
            repeat (phase_len) begin
                queue_tick($urandom_range(1, strobe_every) == 1, next_echo());
                ticks_random++;
            end
            wait_drained();
        end

        $display("ran %0d ticks under %0d register settings", ticks_accepted, settings_used);
        $display("echo readings finished: %0d, of which %0d timed out",
                 readings_done, readings_timeout);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
